@@ rtl/core/b64enc_pkg.sv @@
// Shared types, constants and the alphabet lookup for the Base64 stream encoder.
package b64enc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int CHARS_PER_JOB = 4;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_PLUS = 8'h2B;
    localparam logic [7:0] ASCII_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        GP_0,
        GP_1,
        GP_2
    } t_grp_pos;

    typedef struct packed {
        logic [CHARS_PER_JOB-1:0][7:0] chars;
        logic [1:0]                    last_idx;
        logic                          eom;
    } t_job;

    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return ASCII_UPPER_A + w;
        end else if (v < 6'd52) begin
            return ASCII_LOWER_A + w - 8'd26;
        end else if (v < 6'd62) begin
            return ASCII_ZERO + w - 8'd52;
        end else if (v == 6'd62) begin
            return ASCII_PLUS;
        end else begin
            return ASCII_SLASH;
        end
    endfunction

endpackage

@@ rtl/core/base64_stream_encoder_top.sv @@
// Top level of the Base64 stream encoder.
//
// Input channel s_axis: one raw message byte per transaction in s_axis_tdata,
// s_axis_tlast high on the final byte of a message (every message has one or
// more bytes). Output channel m_axis: one ASCII character per transaction in
// m_axis_tdata (A-Z, a-z, 0-9, '+', '/' or '=' padding), m_axis_tlast high on
// the final character of the encoded message.
// Each byte becomes a job of one to four characters in the front end and
// enters a two-entry job queue. The first character of a byte is registered
// in the job queue and then in the output register. Throughput: one character
// per cycle on m_axis while m_axis_tready is high; a non-final byte gives one
// or two characters and a final byte two to four. The emitter's single output
// port sets this rate. s_axis_tready drops only while the job queue is full.
// Reset clears the group position, leftover bits, queue, character index and
// output valid; the next byte starts a new message. When m_axis_tready is low
// the output character holds, the queue fills, and then s_axis_tready falls.
module base64_stream_encoder_top
    import b64enc_pkg::*;
#(
    parameter int QDepth = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast
);

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_q_valid;
    t_job w_in_job;
    t_job w_head_job;

    b64enc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_final (s_axis_tlast),
        .o_ready (s_axis_tready),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_in_job)
    );

    b64enc_queue #(
        .Depth (QDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_head_job)
    );

    b64enc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_job   (w_head_job),
        .o_pop     (w_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast)
    );

endmodule

@@ rtl/core/b64enc_front.sv @@
// Front end: accepts bytes, tracks the group position and builds character jobs.
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data,
    input  logic       i_final,
    output logic       o_ready,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    t_grp_pos   r_pos, n_pos;
    logic [3:0] r_left, n_left;
    logic       w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= GP_0;
            r_left <= 4'd0;
        end else begin
            r_pos  <= n_pos;
            r_left <= n_left;
        end
    end

    always_comb begin
        n_pos  = r_pos;
        n_left = r_left;
        if (w_accept) begin
            if (i_final) begin
                n_pos  = GP_0;
                n_left = 4'd0;
            end else begin
                unique case (r_pos)
                    GP_1: begin
                        n_pos  = GP_2;
                        n_left = i_data[3:0];
                    end
                    GP_2: begin
                        n_pos  = GP_0;
                        n_left = 4'd0;
                    end
                    default: begin
                        n_pos  = GP_1;
                        n_left = {2'b00, i_data[1:0]};
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_job = '0;
        unique case (r_pos)
            GP_1: begin
                o_job.chars[0] = b64_sym({r_left[1:0], i_data[7:4]});
                if (i_final) begin
                    o_job.chars[1] = b64_sym({i_data[3:0], 2'b00});
                    o_job.chars[2] = PAD_CHAR;
                    o_job.last_idx = 2'd2;
                    o_job.eom      = 1'b1;
                end
            end
            GP_2: begin
                o_job.chars[0] = b64_sym({r_left, i_data[7:6]});
                o_job.chars[1] = b64_sym(i_data[5:0]);
                o_job.last_idx = 2'd1;
                o_job.eom      = i_final;
            end
            default: begin
                o_job.chars[0] = b64_sym(i_data[7:2]);
                if (i_final) begin
                    o_job.chars[1] = b64_sym({i_data[1:0], 4'b0000});
                    o_job.chars[2] = PAD_CHAR;
                    o_job.chars[3] = PAD_CHAR;
                    o_job.last_idx = 2'd3;
                    o_job.eom      = 1'b1;
                end
            end
        endcase
    end

    a_final_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_final) |=> (r_pos == GP_0 && r_left == 4'd0))
        else $error("group state not cleared after final byte");

    a_left_narrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == GP_1) |-> (r_left[3:2] == 2'b00))
        else $error("leftover holds more than two bits at position one");

endmodule

@@ rtl/core/b64enc_queue.sv @@
// Short job queue between the front end and the character emitter.
module b64enc_queue
    import b64enc_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    t_job            r_mem [Depth];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CntFull);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PtrLast) ? '0 : r_wr + PtrW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrLast) ? '0 : r_rd + PtrW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CntW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntFull)
        else $error("queue count above depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("pop from empty queue");

endmodule

@@ rtl/core/b64enc_back.sv @@
// Back end: walks the characters of each job into the output register.
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_q_job,
    output logic       o_pop,
    output logic       o_tvalid,
    input  logic       i_tready,
    output logic [7:0] o_tdata,
    output logic       o_tlast
);

    logic [1:0] r_idx, n_idx;
    logic       r_tvalid, n_tvalid;
    logic [7:0] r_tdata;
    logic       r_tlast;
    logic       w_load;
    logic       w_job_done;

    assign w_load     = i_q_valid && (!r_tvalid || i_tready);
    assign w_job_done = (r_idx == i_q_job.last_idx);
    assign o_pop      = w_load && w_job_done;

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

    always_comb begin
        n_idx    = r_idx;
        n_tvalid = r_tvalid;
        if (w_load) begin
            n_tvalid = 1'b1;
            n_idx    = w_job_done ? 2'd0 : r_idx + 2'd1;
        end else if (i_tready) begin
            n_tvalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= 2'd0;
            r_tvalid <= 1'b0;
        end else begin
            r_idx    <= n_idx;
            r_tvalid <= n_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tdata <= i_q_job.chars[r_idx];
            r_tlast <= i_q_job.eom && w_job_done;
        end
    end

    a_mid_job_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> i_q_valid)
        else $error("job head lost while characters remain");

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> (r_idx <= i_q_job.last_idx))
        else $error("character index past end of job");

endmodule

@@ sim/tb_base64_stream_encoder_top.sv @@
// Self-checking testbench for the Base64 stream encoder: random stream traffic against a predictor.
`timescale 1ns / 1ps

module tb_base64_stream_encoder_top;
    import b64enc_pkg::*;

    typedef struct {
        logic [7:0] data_byte;
        logic       is_final;
    } t_raw_byte;

    typedef struct {
        logic [7:0] out_char;
        logic       end_of_message;
    } t_enc_char;

    localparam logic [0:63][7:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;    // [7:0] data_byte
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_char
    logic       m_axis_tlast;

    t_raw_byte  raw_bytes[$];
    t_enc_char  enc_chars[$];
    t_grp_pos   grp_pos = GP_0;
    logic [3:0] left_bits = 4'h0;
    int         src_idle_pct = 0;
    int         sink_idle_pct = 0;
    int         err_count = 0;

    base64_stream_encoder_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void add_char(input logic [7:0] ch, input logic eom);
        t_enc_char c;
        c.out_char = ch;
        c.end_of_message = eom;
        enc_chars.push_back(c);
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        case (grp_pos)
            GP_1: begin
                add_char(B64_ALPHABET[{left_bits[1:0], b[7:4]}], 1'b0);
                if (fin) begin
                    add_char(B64_ALPHABET[{b[3:0], 2'b00}], 1'b0);
                    add_char(PAD_CHAR, 1'b1);
                end else begin
                    left_bits = b[3:0];
                    grp_pos = GP_2;
                end
            end
            GP_2: begin
                add_char(B64_ALPHABET[{left_bits, b[7:6]}], 1'b0);
                add_char(B64_ALPHABET[b[5:0]], fin);
                left_bits = 4'h0;
                grp_pos = GP_0;
            end
            default: begin
                add_char(B64_ALPHABET[b[7:2]], 1'b0);
                if (fin) begin
                    add_char(B64_ALPHABET[{b[1:0], 4'h0}], 1'b0);
                    add_char(PAD_CHAR, 1'b0);
                    add_char(PAD_CHAR, 1'b1);
                end else begin
                    left_bits = {2'b00, b[1:0]};
                    grp_pos = GP_1;
                end
            end
        endcase
        if (fin) begin
            grp_pos = GP_0;
            left_bits = 4'h0;
        end
    endfunction

    function automatic void queue_byte(input logic [7:0] b, input logic fin);
        t_raw_byte r;
        r.data_byte = b;
        r.is_final = fin;
        raw_bytes.push_back(r);
    endfunction

    function automatic int queue_message(input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0: b = 8'h00;
                1: b = 8'hFF;
                default: b = 8'($urandom);
            endcase
            queue_byte(b, i == len - 1);
        end
        return len;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_raw_byte  r;
        logic       nxt_valid;
        logic [7:0] nxt_data;
        logic       nxt_last;
        nxt_valid = s_axis_tvalid;
        nxt_data = s_axis_tdata;
        nxt_last = s_axis_tlast;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                encode_byte(s_axis_tdata, s_axis_tlast);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (raw_bytes.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    r = raw_bytes.pop_front();
                    nxt_valid = 1'b1;
                    nxt_data = r.data_byte;
                    nxt_last = r.is_final;
                end else begin
                    nxt_valid = 1'b0;
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata <= nxt_data;
        s_axis_tlast <= nxt_last;
    end

    // monitor
    always @(posedge i_clk) begin
        t_enc_char c;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (enc_chars.size() == 0) begin
                    $display("%0t MISMATCH unexpected char: expected none, actual %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    err_count++;
                end else begin
                    c = enc_chars.pop_front();
                    if (m_axis_tdata !== c.out_char) begin
                        $display("%0t MISMATCH out_char: expected %h, actual %h",
                                 $time, c.out_char, m_axis_tdata);
                        err_count++;
                    end
                    if (m_axis_tlast !== c.end_of_message) begin
                        $display("%0t MISMATCH end_of_message: expected %b, actual %b",
                                 $time, c.end_of_message, m_axis_tlast);
                        err_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    initial begin
        int sent;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 64 : 0;
            sink_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 23 : 0;
            if (ph == 0) begin
                // final byte at every group position, extremes of the byte
                queue_byte(8'h00, 1'b1);
                queue_byte(8'hFF, 1'b1);
                queue_byte(8'hFF, 1'b0);
                queue_byte(8'h00, 1'b1);
                queue_byte(8'h00, 1'b0);
                queue_byte(8'hFF, 1'b0);
                queue_byte(8'hA5, 1'b1);
                queue_byte(8'hFB, 1'b0);
                queue_byte(8'hEF, 1'b0);
                queue_byte(8'hBE, 1'b0);
                queue_byte(8'hFF, 1'b1);
                queue_byte(8'h4D, 1'b0);
                queue_byte(8'h61, 1'b0);
                queue_byte(8'h6E, 1'b0);
                queue_byte(8'h5A, 1'b1);
                queue_byte(8'h00, 1'b0);
                queue_byte(8'h00, 1'b0);
                queue_byte(8'h00, 1'b0);
                queue_byte(8'h00, 1'b0);
                queue_byte(8'h00, 1'b1);
            end
            sent = 0;
            while (sent < 150) begin
                if ($urandom_range(0, 7) == 0) begin
                    sent += queue_message($urandom_range(13, 40));
                end else begin
                    sent += queue_message($urandom_range(1, 12));
                end
            end
            while (raw_bytes.size() != 0 || s_axis_tvalid) @(negedge i_clk);
        end

        while (enc_chars.size() != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
